// ----- hdl/wfm_pkg.sv -----
// Shared constants, types and constant tables of the windowed FFT magnitude block.
package wfm_pkg;

    localparam int FFT_POINTS = 128;
    localparam int LOG2N      = $clog2(FFT_POINTS);
    localparam int HALF       = FFT_POINTS / 2;
    localparam int HALF_W     = LOG2N - 1;
    localparam int STAGE_W    = $clog2(LOG2N);
    localparam int SMP_W      = 16;
    localparam int COS_W      = 32;
    localparam int WIN_W      = 31;
    localparam int WPROD_W    = SMP_W + COS_W;
    localparam int WORK_W     = 17 + LOG2N;
    localparam int PROD_W     = COS_W + WORK_W;
    localparam int FRAC_W     = 30;
    localparam int SQ_W       = 2 * WORK_W;
    localparam int SUMSQ_W    = SQ_W + 1;
    localparam int MAG_SHIFT  = 2 * LOG2N - 2;
    localparam int RAD_RAW_W  = SUMSQ_W - MAG_SHIFT;
    localparam int SQ_IN_W    = RAD_RAW_W + (RAD_RAW_W % 2);
    localparam int SQ_STEPS   = SQ_IN_W / 2;
    localparam int SQ_ROOT_W  = SQ_STEPS;
    localparam int SQ_REM_W   = SQ_ROOT_W + 3;
    localparam int BIN_W      = 6;
    localparam int MAG_W      = 16;

    localparam longint ONE_Q30          = 64'sd1 << 30;
    localparam longint unsigned PI_Q30  = 64'd3373259426;

    typedef logic signed [COS_W-1:0] cos_tab_t [FFT_POINTS];

    // Control sequencer states
    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_WIN,
        ST_BF_RD,
        ST_BF_LD,
        ST_BF_MUL,
        ST_BF_WA,
        ST_BF_WB,
        ST_MAG
    } st_t;

    // One beat travelling down the square-root chain
    typedef struct packed {
        logic                 vld;
        logic [SQ_IN_W-1:0]   rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
        logic [HALF_W-1:0]    idx;
        logic                 last;
    } sq_cell_t;

    // Quarter-wave cosine in Q1.30 by truncated Taylor series
    function automatic longint cos_quarter(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sm;
        if (k == 0) begin
            return ONE_Q30;
        end
        if (k >= FFT_POINTS / 4) begin
            return 0;
        end
        x    = (64'd2 * PI_Q30 * longint'(k)) / FFT_POINTS;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sm   = ONE_Q30;
        // Eight terms past 1, term i divided by (2i-1)(2i), signs alternating
        term = ((term * x2) >> 30) / 64'd2;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 64'd12;
        sm   = sm + longint'(term);
        term = ((term * x2) >> 30) / 64'd30;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 64'd56;
        sm   = sm + longint'(term);
        term = ((term * x2) >> 30) / 64'd90;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 64'd132;
        sm   = sm + longint'(term);
        term = ((term * x2) >> 30) / 64'd182;
        sm   = sm - longint'(term);
        term = ((term * x2) >> 30) / 64'd240;
        sm   = sm + longint'(term);
        if (sm < 0) begin
            sm = 0;
        end
        if (sm > ONE_Q30) begin
            sm = ONE_Q30;
        end
        return sm;
    endfunction

    function automatic longint cos_full(int k);
        if (k <= FFT_POINTS / 4) begin
            return cos_quarter(k);
        end
        if (k < FFT_POINTS / 2) begin
            return -cos_quarter(FFT_POINTS / 2 - k);
        end
        if (k <= FFT_POINTS / 2 + FFT_POINTS / 4) begin
            return -cos_quarter(k - FFT_POINTS / 2);
        end
        return cos_quarter(FFT_POINTS - k);
    endfunction

    function automatic cos_tab_t build_cos();
        cos_tab_t t;
        for (int k = 0; k < FFT_POINTS; k++) begin
            t[k] = COS_W'(cos_full(k));
        end
        return t;
    endfunction

    localparam cos_tab_t COS_ROM = build_cos();

    function automatic logic [LOG2N-1:0] bit_rev(logic [LOG2N-1:0] v);
        logic [LOG2N-1:0] r;
        for (int b = 0; b < LOG2N; b++) begin
            r[b] = v[LOG2N-1-b];
        end
        return r;
    endfunction

endpackage

// ----- hdl/wfm_sqrt_cell.sv -----
// One cell of the square-root chain: resolves one root bit per beat.
module wfm_sqrt_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  wfm_pkg::sq_cell_t  cell_in,
    output wfm_pkg::sq_cell_t  cell_out
);

    wfm_pkg::sq_cell_t cell_reg;
    wfm_pkg::sq_cell_t cell_next;
    logic [wfm_pkg::SQ_REM_W-1:0] rem_sh;
    logic [wfm_pkg::SQ_REM_W-1:0] trial;

    // Restoring step on the next two radicand bits
    always_comb begin
        rem_sh    = {cell_in.rem[wfm_pkg::SQ_REM_W-3:0],
                     cell_in.rad[wfm_pkg::SQ_IN_W-1 -: 2]};
        trial     = wfm_pkg::SQ_REM_W'({cell_in.root, 2'b01});
        cell_next = cell_in;
        cell_next.rad = {cell_in.rad[wfm_pkg::SQ_IN_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
            cell_next.rem  = rem_sh - trial;
            cell_next.root = {cell_in.root[wfm_pkg::SQ_ROOT_W-2:0], 1'b1};
        end else begin
            cell_next.rem  = rem_sh;
            cell_next.root = {cell_in.root[wfm_pkg::SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.vld <= 1'b0;
        end else if (en) begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;

endmodule

// ----- hdl/wfm_bfly.sv -----
// Radix-2 butterfly: twiddle multiply with rounding, then sum and difference.
module wfm_bfly (
    input  logic                                aclk,
    input  logic                                in_en,
    input  logic signed [wfm_pkg::WORK_W-1:0]   a_re,
    input  logic signed [wfm_pkg::WORK_W-1:0]   a_im,
    input  logic signed [wfm_pkg::WORK_W-1:0]   b_re,
    input  logic signed [wfm_pkg::WORK_W-1:0]   b_im,
    input  logic signed [wfm_pkg::COS_W-1:0]    w_re,
    input  logic signed [wfm_pkg::COS_W-1:0]    w_im,
    output logic signed [wfm_pkg::WORK_W-1:0]   sum_re,
    output logic signed [wfm_pkg::WORK_W-1:0]   sum_im,
    output logic signed [wfm_pkg::WORK_W-1:0]   dif_re,
    output logic signed [wfm_pkg::WORK_W-1:0]   dif_im
);

    localparam int ACC_W = wfm_pkg::PROD_W + 1;

    logic signed [wfm_pkg::PROD_W-1:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [wfm_pkg::WORK_W-1:0] a_re_reg, a_im_reg;
    logic signed [ACC_W-1:0]           acc_re, acc_im;
    logic signed [wfm_pkg::WORK_W-1:0] t_re, t_im;
    logic signed [wfm_pkg::WORK_W-1:0] sum_re_reg, sum_im_reg, dif_re_reg, dif_im_reg;

    // Products
    always_ff @(posedge aclk) begin
        if (in_en) begin
            p_rr_reg <= w_re * b_re;
            p_ii_reg <= w_im * b_im;
            p_ri_reg <= w_re * b_im;
            p_ir_reg <= w_im * b_re;
            a_re_reg <= a_re;
            a_im_reg <= a_im;
        end
    end

    // Round half up back to the work scale
    always_comb begin
        acc_re = ACC_W'(p_rr_reg) - ACC_W'(p_ii_reg)
               + (ACC_W'(1) <<< (wfm_pkg::FRAC_W - 1));
        acc_im = ACC_W'(p_ri_reg) + ACC_W'(p_ir_reg)
               + (ACC_W'(1) <<< (wfm_pkg::FRAC_W - 1));
        t_re   = wfm_pkg::WORK_W'(acc_re >>> wfm_pkg::FRAC_W);
        t_im   = wfm_pkg::WORK_W'(acc_im >>> wfm_pkg::FRAC_W);
    end

    always_ff @(posedge aclk) begin
        sum_re_reg <= a_re_reg + t_re;
        sum_im_reg <= a_im_reg + t_im;
        dif_re_reg <= a_re_reg - t_re;
        dif_im_reg <= a_im_reg - t_im;
    end

    assign sum_re = sum_re_reg;
    assign sum_im = sum_im_reg;
    assign dif_re = dif_re_reg;
    assign dif_im = dif_im_reg;

endmodule

// ----- hdl/windowed_fft_magnitude.sv -----
// Top level: sample store, Hann window, in-place radix-2 FFT, magnitude chain.
// Throughput: N samples at one per cycle while s_valid and s_ready are high; s_ready
//   is high only in the collect state, so no samples are taken while a frame is processed.
//   The shared butterfly unit runs one butterfly at a time through the states BF_RD,
//   BF_LD, BF_MUL, BF_WA and BF_WB. Then N/2 bins leave at up to one per cycle
//   while m_ready allows.
// Reset: synchronous, active low; clears the sequencer, fill count and valids.
module windowed_fft_magnitude (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [wfm_pkg::SMP_W-1:0] s_sample,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [wfm_pkg::BIN_W-1:0]     m_bin_index,
    output logic [wfm_pkg::MAG_W-1:0]     m_magnitude,
    output logic                          m_last_bin
);

    localparam int N   = wfm_pkg::FFT_POINTS;
    localparam int LG  = wfm_pkg::LOG2N;
    localparam int WW  = wfm_pkg::WORK_W;
    localparam int HW  = wfm_pkg::HALF_W;

    wfm_pkg::st_t state_reg, state_next;

    logic [LG-1:0]                 fill_reg, fill_next;
    logic [LG:0]                   win_cnt_reg, win_cnt_next;
    logic [wfm_pkg::STAGE_W-1:0]   stage_reg, stage_next;
    logic [HW-1:0]                 bf_reg, bf_next;
    logic [HW:0]                   mag_cnt_reg, mag_cnt_next;

    // Memories
    logic signed [wfm_pkg::SMP_W-1:0] sample_mem [N];
    logic [2*WW-1:0]                  work_mem [N];
    logic signed [wfm_pkg::SMP_W-1:0] smp_q_reg;
    logic [2*WW-1:0]                  rda_q_reg, rdb_q_reg;
    logic                             rda_en;
    logic [LG-1:0]                    rda_addr, rdb_addr;
    logic                             wr_en;
    logic [LG-1:0]                    wr_addr;
    logic [2*WW-1:0]                  wr_data;

    logic s_fire;
    logic adv;

    // Window pipeline
    logic                             win_issue;
    logic                             w1_vld_reg, w2_vld_reg;
    logic [LG-1:0]                    w1_idx_reg, w2_idx_reg;
    logic [wfm_pkg::WIN_W-1:0]        w1_win_reg;
    logic signed [wfm_pkg::WPROD_W-1:0] w2_prod_reg;
    logic signed [wfm_pkg::WPROD_W-1:0] w_rnd;
    logic signed [wfm_pkg::COS_W:0]   win_wide;
    logic signed [WW-1:0]             win_val;

    // Butterfly addressing
    logic [HW-1:0]                    bf_mask, bf_lo, bf_hi;
    logic [LG-1:0]                    addr_a, addr_b, tw_idx, sin_idx;
    logic [wfm_pkg::STAGE_W-1:0]      tw_shift;
    logic signed [wfm_pkg::COS_W-1:0] tw_re_reg, tw_im_reg;
    logic                             bf_en;
    logic signed [WW-1:0]             bf_sum_re, bf_sum_im, bf_dif_re, bf_dif_im;

    // Magnitude pipeline
    logic                             mag_issue;
    logic                             mp1_vld_reg, mp2_vld_reg, mp3_vld_reg;
    logic [HW-1:0]                    mp1_idx_reg, mp2_idx_reg, mp3_idx_reg;
    logic signed [WW-1:0]             mre, mim;
    logic [WW-1:0]                    abs_re, abs_im;
    logic [wfm_pkg::SQ_W-1:0]         sq_re_reg, sq_im_reg;
    logic [wfm_pkg::SUMSQ_W-1:0]      sumsq;
    logic [wfm_pkg::SQ_IN_W-1:0]      mp3_rad_reg;
    wfm_pkg::sq_cell_t                chain [wfm_pkg::SQ_STEPS+1];
    wfm_pkg::sq_cell_t                chain_out;

    logic                             m_valid_reg;
    logic [wfm_pkg::BIN_W-1:0]        m_bin_reg;
    logic [wfm_pkg::MAG_W-1:0]        m_mag_reg;
    logic                             m_last_reg;

    assign s_ready = (state_reg == wfm_pkg::ST_COLLECT);
    assign s_fire  = s_valid && s_ready;
    assign adv     = !m_valid_reg || m_ready;

    // Butterfly addresses and twiddle index from stage and butterfly counters
    always_comb begin
        bf_mask  = HW'((1 << stage_reg) - 1);
        bf_lo    = bf_reg & bf_mask;
        bf_hi    = bf_reg & ~bf_mask;
        addr_a   = {bf_hi, 1'b0} | LG'(bf_lo);
        addr_b   = addr_a | LG'(1 << stage_reg);
        tw_shift = wfm_pkg::STAGE_W'(LG - 1) - stage_reg;
        tw_idx   = LG'(bf_lo) << tw_shift;
        sin_idx  = tw_idx + LG'(3 * (N / 4));
    end

    assign win_issue = (state_reg == wfm_pkg::ST_WIN) && (win_cnt_reg < (LG+1)'(N));
    assign mag_issue = (state_reg == wfm_pkg::ST_MAG) && (mag_cnt_reg < (HW+1)'(N / 2))
                       && adv;
    assign bf_en     = (state_reg == wfm_pkg::ST_BF_LD);

    // Sequencer next state
    always_comb begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        win_cnt_next = win_cnt_reg;
        stage_next   = stage_reg;
        bf_next      = bf_reg;
        mag_cnt_next = mag_cnt_reg;
        unique case (state_reg)
            wfm_pkg::ST_COLLECT: begin
                if (s_fire) begin
                    fill_next = fill_reg + 1'b1;
                    if (fill_reg == LG'(N - 1)) begin
                        state_next   = wfm_pkg::ST_WIN;
                        win_cnt_next = '0;
                    end
                end
            end
            wfm_pkg::ST_WIN: begin
                if (win_issue) begin
                    win_cnt_next = win_cnt_reg + 1'b1;
                end else if (!w1_vld_reg && !w2_vld_reg) begin
                    state_next = wfm_pkg::ST_BF_RD;
                    stage_next = '0;
                    bf_next    = '0;
                end
            end
            wfm_pkg::ST_BF_RD:  state_next = wfm_pkg::ST_BF_LD;
            wfm_pkg::ST_BF_LD:  state_next = wfm_pkg::ST_BF_MUL;
            wfm_pkg::ST_BF_MUL: state_next = wfm_pkg::ST_BF_WA;
            wfm_pkg::ST_BF_WA:  state_next = wfm_pkg::ST_BF_WB;
            wfm_pkg::ST_BF_WB: begin
                state_next = wfm_pkg::ST_BF_RD;
                if (bf_reg == HW'(N / 2 - 1)) begin
                    bf_next = '0;
                    if (stage_reg == wfm_pkg::STAGE_W'(LG - 1)) begin
                        state_next   = wfm_pkg::ST_MAG;
                        mag_cnt_next = '0;
                    end else begin
                        stage_next = stage_reg + 1'b1;
                    end
                end else begin
                    bf_next = bf_reg + 1'b1;
                end
            end
            wfm_pkg::ST_MAG: begin
                if (mag_issue) begin
                    mag_cnt_next = mag_cnt_reg + 1'b1;
                end
                if (adv && chain_out.vld && chain_out.last) begin
                    state_next = wfm_pkg::ST_COLLECT;
                end
            end
            default: state_next = wfm_pkg::ST_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= wfm_pkg::ST_COLLECT;
            fill_reg    <= '0;
            win_cnt_reg <= '0;
            stage_reg   <= '0;
            bf_reg      <= '0;
            mag_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            win_cnt_reg <= win_cnt_next;
            stage_reg   <= stage_next;
            bf_reg      <= bf_next;
            mag_cnt_reg <= mag_cnt_next;
        end
    end

    // Sample store
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            sample_mem[fill_reg] <= s_sample;
        end
        smp_q_reg <= sample_mem[win_cnt_reg[LG-1:0]];
    end

    // Window: read, multiply, round and write in bit-reversed order
    assign win_wide = (wfm_pkg::COS_W+1)'(wfm_pkg::ONE_Q30)
                    - (wfm_pkg::COS_W+1)'(wfm_pkg::COS_ROM[win_cnt_reg[LG-1:0]]);
    assign w_rnd    = (w2_prod_reg + (wfm_pkg::WPROD_W'(1) <<< (wfm_pkg::FRAC_W - 1)))
                      >>> wfm_pkg::FRAC_W;
    assign win_val  = WW'(w_rnd);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w1_vld_reg <= 1'b0;
            w2_vld_reg <= 1'b0;
        end else begin
            w1_vld_reg <= win_issue;
            w2_vld_reg <= w1_vld_reg;
        end
        w1_idx_reg  <= win_cnt_reg[LG-1:0];
        w1_win_reg  <= wfm_pkg::WIN_W'(win_wide >>> 1);
        w2_idx_reg  <= w1_idx_reg;
        w2_prod_reg <= smp_q_reg * $signed({1'b0, w1_win_reg});
    end

    // Twiddle registers, loaded with the butterfly reads
    always_ff @(posedge aclk) begin
        if (state_reg == wfm_pkg::ST_BF_RD) begin
            tw_re_reg <= wfm_pkg::COS_ROM[tw_idx];
            tw_im_reg <= -wfm_pkg::COS_ROM[sin_idx];
        end
    end

    wfm_bfly u_bfly (
        .aclk   (aclk),
        .in_en  (bf_en),
        .a_re   (rda_q_reg[2*WW-1:WW]),
        .a_im   (rda_q_reg[WW-1:0]),
        .b_re   (rdb_q_reg[2*WW-1:WW]),
        .b_im   (rdb_q_reg[WW-1:0]),
        .w_re   (tw_re_reg),
        .w_im   (tw_im_reg),
        .sum_re (bf_sum_re),
        .sum_im (bf_sum_im),
        .dif_re (bf_dif_re),
        .dif_im (bf_dif_im)
    );

    // Work store ports
    always_comb begin
        rda_en   = (state_reg == wfm_pkg::ST_BF_RD) || ((state_reg == wfm_pkg::ST_MAG) && adv);
        rda_addr = (state_reg == wfm_pkg::ST_MAG) ? LG'(mag_cnt_reg[HW-1:0]) : addr_a;
        rdb_addr = addr_b;
        wr_en    = 1'b0;
        wr_addr  = addr_a;
        wr_data  = {bf_sum_re, bf_sum_im};
        case (state_reg)
            wfm_pkg::ST_WIN: begin
                wr_en   = w2_vld_reg;
                wr_addr = wfm_pkg::bit_rev(w2_idx_reg);
                wr_data = {win_val, WW'(0)};
            end
            wfm_pkg::ST_BF_WA: begin
                wr_en = 1'b1;
            end
            wfm_pkg::ST_BF_WB: begin
                wr_en   = 1'b1;
                wr_addr = addr_b;
                wr_data = {bf_dif_re, bf_dif_im};
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            work_mem[wr_addr] <= wr_data;
        end
        if (rda_en) begin
            rda_q_reg <= work_mem[rda_addr];
        end
        rdb_q_reg <= work_mem[rdb_addr];
    end

    // Magnitude pipeline: squares, scaled sum, then the root chain
    always_comb begin
        mre    = rda_q_reg[2*WW-1:WW];
        mim    = rda_q_reg[WW-1:0];
        abs_re = mre[WW-1] ? WW'(-mre) : WW'(mre);
        abs_im = mim[WW-1] ? WW'(-mim) : WW'(mim);
        sumsq  = {1'b0, sq_re_reg} + {1'b0, sq_im_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mp1_vld_reg <= 1'b0;
            mp2_vld_reg <= 1'b0;
            mp3_vld_reg <= 1'b0;
        end else if (adv) begin
            mp1_vld_reg <= mag_issue;
            mp2_vld_reg <= mp1_vld_reg;
            mp3_vld_reg <= mp2_vld_reg;
        end
        if (adv) begin
            mp1_idx_reg <= mag_cnt_reg[HW-1:0];
            mp2_idx_reg <= mp1_idx_reg;
            mp3_idx_reg <= mp2_idx_reg;
            sq_re_reg   <= abs_re * abs_re;
            sq_im_reg   <= abs_im * abs_im;
            mp3_rad_reg <= wfm_pkg::SQ_IN_W'(sumsq[wfm_pkg::SUMSQ_W-1:wfm_pkg::MAG_SHIFT]);
        end
    end

    always_comb begin
        chain[0].vld  = mp3_vld_reg;
        chain[0].rad  = mp3_rad_reg;
        chain[0].rem  = '0;
        chain[0].root = '0;
        chain[0].idx  = mp3_idx_reg;
        chain[0].last = (mp3_idx_reg == HW'(N / 2 - 1));
    end

    for (genvar g = 0; g < wfm_pkg::SQ_STEPS; g++) begin : g_sqrt
        wfm_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    assign chain_out = chain[wfm_pkg::SQ_STEPS];

    // Output register, saturating the root
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= chain_out.vld;
        end
        if (adv) begin
            m_bin_reg  <= wfm_pkg::BIN_W'(chain_out.idx);
            m_last_reg <= chain_out.last;
            if (chain_out.root[wfm_pkg::SQ_ROOT_W-1:wfm_pkg::MAG_W] != '0) begin
                m_mag_reg <= '1;
            end else begin
                m_mag_reg <= chain_out.root[wfm_pkg::MAG_W-1:0];
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_bin_index = m_bin_reg;
    assign m_magnitude = m_mag_reg;
    assign m_last_bin  = m_last_reg;

endmodule

// ----- bench/tb.sv -----
// Testbench of the windowed FFT magnitude block: one frame of samples against a bit-exact predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N         = wfm_pkg::FFT_POINTS;
    localparam int LG        = wfm_pkg::LOG2N;
    localparam int SW        = wfm_pkg::SMP_W;
    localparam int BW        = wfm_pkg::BIN_W;
    localparam int MW        = wfm_pkg::MAG_W;
    localparam int LIMIT     = 400000;
    localparam int TAIL      = 3000;
    localparam int ITEMS     = N;
    localparam int DIR_ROWS  = 32;

    typedef struct packed {
        logic [BW-1:0] bin;
        logic [MW-1:0] mag;
        logic          last;
    } bin_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [SW-1:0] s_sample = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [BW-1:0] m_bin_index;
    logic [MW-1:0] m_magnitude;
    logic m_last_bin;

    windowed_fft_magnitude i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_sample(s_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_bin_index(m_bin_index),
        .m_magnitude(m_magnitude), .m_last_bin(m_last_bin)
    );

    always #5 aclk = ~aclk;

    // predictor state
    longint       cos_t [N];
    logic signed [SW-1:0] frame_buf [N];
    int           fill;
    bin_t         bins_due [$];
    int           errors = 0;
    int           cycles = 0;
    int           rcv_cnt = 0;
    int           src_idle = 6;
    int           snk_idle = 80;

    // directed rows: extremes, zero and unit steps at the head of the frame
    logic signed [SW-1:0] dir_smp [DIR_ROWS];

    function automatic longint rnd_half_up(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint c_quarter(int k);
        longint unsigned x, x2, term;
        longint sm;
        if (k == 0) return longint'(1) << 30;
        if (k >= N / 4) return 0;
        x    = (64'd2 * 64'd3373259426 * longint'(k)) / N;
        x2   = (x * x) >> 30;
        term = 64'd1 << 30;
        sm   = longint'(1) << 30;
        for (int i = 1; i <= 8; i++) begin
            term = ((term * x2) >> 30) / longint'((2 * i - 1) * (2 * i));
            if (i % 2) sm -= longint'(term);
            else sm += longint'(term);
        end
        if (sm < 0) sm = 0;
        if (sm > (longint'(1) << 30)) sm = longint'(1) << 30;
        return sm;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // windowed in-place FFT of the held frame, queue the N/2 bins
    task automatic spectrum_predict();
        longint re [N];
        longint im [N];
        longint w, wr, wi, br, bi, tr, ti, ar, ai;
        longint unsigned sq, m;
        int r, a, b, half, stride;
        bin_t e;
        for (int i = 0; i < N; i++) begin
            w = ((longint'(1) << 30) - cos_t[i]) / 2;
            r = 0;
            for (int k = 0; k < LG; k++) r |= ((i >> k) & 1) << (LG - 1 - k);
            re[r] = rnd_half_up(longint'(frame_buf[i]) * w, 30);
            im[r] = 0;
        end
        for (int len = 2; len <= N; len <<= 1) begin
            half = len / 2;
            stride = N / len;
            for (int bs = 0; bs < N; bs += len) begin
                for (int j = 0; j < half; j++) begin
                    a = bs + j;
                    b = a + half;
                    wr = cos_t[(j * stride) % N];
                    wi = -cos_t[(j * stride + 3 * N / 4) % N];
                    br = re[b];
                    bi = im[b];
                    tr = rnd_half_up(wr * br - wi * bi, 30);
                    ti = rnd_half_up(wr * bi + wi * br, 30);
                    re[b] = re[a] - tr;
                    im[b] = im[a] - ti;
                    re[a] = re[a] + tr;
                    im[a] = im[a] + ti;
                end
            end
        end
        for (int i = 0; i < N / 2; i++) begin
            ar = re[i] < 0 ? -re[i] : re[i];
            ai = im[i] < 0 ? -im[i] : im[i];
            sq = longint'(ar * ar) + longint'(ai * ai);
            m = root_floor(sq >> (2 * LG - 2));
            if (m > 65535) m = 65535;
            e.bin = BW'(i);
            e.mag = MW'(m);
            e.last = (i == N / 2 - 1);
            bins_due.push_back(e);
        end
    endtask

    task automatic sample_accepted(input logic signed [SW-1:0] smp);
        frame_buf[fill] = smp;
        fill++;
        if (fill == N) begin
            fill = 0;
            spectrum_predict();
        end
    endtask

    // send one beat, changing inputs on the falling edge; valid drops only while idling
    task automatic send_sample(input logic signed [SW-1:0] smp);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sample_accepted(smp);
        @(negedge aclk);
    endtask

    function automatic logic signed [SW-1:0] rand_sample(int kind);
        case (kind)
            0: return SW'($urandom);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            2: return SW'($signed($urandom_range(64)) - 32);
            default: return SW'($urandom_range(65535));
        endcase
    endfunction

    // receiver and checker; receiver idling follows the count of bins taken
    always @(posedge aclk) begin
        bin_t e;
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            rcv_cnt++;
            if (bins_due.size() == 0) begin
                $error("bin beat with nothing expected: bin_index %0d", m_bin_index);
                errors++;
            end else begin
                e = bins_due.pop_front();
                if (m_bin_index !== e.bin) begin
                    $error("bin_index expected %0d actual %0d", e.bin, m_bin_index);
                    errors++;
                end
                if (m_magnitude !== e.mag) begin
                    $error("magnitude expected %0d actual %0d", e.mag, m_magnitude);
                    errors++;
                end
                if (m_last_bin !== e.last) begin
                    $error("last_bin expected %0d actual %0d", e.last, m_last_bin);
                    errors++;
                end
            end
        end
        if (rcv_cnt < N / 6) snk_idle = 80;
        else if (rcv_cnt < N / 3) snk_idle = 6;
        else snk_idle = 0;
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_idle);
    end

    // watchdog
    always @(posedge aclk) begin
        if (cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic signed [SW-1:0] smp;
        for (int k = 0; k < N; k++) begin
            if (k <= N / 4) cos_t[k] = c_quarter(k);
            else if (k < N / 2) cos_t[k] = -c_quarter(N / 2 - k);
            else if (k <= 3 * N / 4) cos_t[k] = -c_quarter(k - N / 2);
            else cos_t[k] = c_quarter(N - k);
        end
        fill = 0;
        // directed table: full-scale extremes, zero and unit steps
        for (int i = 0; i < DIR_ROWS; i++) begin
            case (i % 4)
                0: dir_smp[i] = 16'sh7fff;
                1: dir_smp[i] = 16'sh8000;
                2: dir_smp[i] = '0;
                default: dir_smp[i] = (i < DIR_ROWS / 2) ? 16'sh0001 : 16'shffff;
            endcase
        end
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // one frame: directed rows, then random samples; sender idling in three phases
        for (int i = 0; i < ITEMS; i++) begin
            if (i < ITEMS / 3) src_idle = 6;
            else if (i < 2 * ITEMS / 3) src_idle = 80;
            else src_idle = 0;
            if (i < DIR_ROWS) smp = dir_smp[i];
            else smp = rand_sample($urandom_range(3));
            send_sample(smp);
        end
        s_valid <= 1'b0;

        while (bins_due.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        if (errors == 0 && bins_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
